// ----- rtl/core/chacha20_stream_cipher_top_assert.svh -----
// ----------------------------------------------------------------------------
// ChaCha20 stream cipher assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef CHACHA20_STREAM_CIPHER_TOP_ASSERT_SVH
`define CHACHA20_STREAM_CIPHER_TOP_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define CC20_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cc20 port check failed");

// Next-cycle implication, disabled in reset
`define CC20_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cc20 port check failed");

`endif

// ----- rtl/core/cc20_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ChaCha20 shared definitions
// Item types, register indexes, microcode format and quarter-round helpers.
// ----------------------------------------------------------------------------
package cc20_pkg;

   // Register indexes on the write port
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY0     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY1     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY2     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY3     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NONCE_LO = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_NONCE_HI = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_CTR = 3'd6;

   // "expand 32-byte k"
   localparam logic [3:0][31:0] SIGMA = {32'h6b206574, 32'h79622d32,
                                         32'h3320646e, 32'h61707865};

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_message;
   } rsp_item_type;

   // Key and nonce as held in the register file
   typedef struct packed {
      logic [3:0][63:0] key;
      logic [63:0]      nonce_low;
      logic [31:0]      nonce_high;
   } key_cfg_type;

   // Request from the stream control to the block engine
   typedef struct packed {
      logic        start;
      logic [31:0] counter;
   } blk_req_type;

   typedef logic [15:0][31:0] words_type;

   // Microcode
   localparam int UC_PC_W = 4;
   localparam logic [UC_PC_W-1:0] UC_LOOP_TARGET = 4'd1;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_ROUND = 2'd1,
      OP_FEED  = 2'd2
   } op_type;

   // One line of the quarter round: add, xor, rotate
   typedef enum logic [1:0] {
      LN_A16 = 2'd0,
      LN_C12 = 2'd1,
      LN_A8  = 2'd2,
      LN_C7  = 2'd3
   } line_type;

   typedef struct packed {
      op_type   op;
      line_type line;
      logic     diag;
      logic     loop;
   } ucode_type;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
   } quad_type;

   function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
      return (v << n) | (v >> (32 - n));
   endfunction

   function automatic quad_type qr_line(input line_type ln, input quad_type q);
      quad_type    r;
      logic [31:0] s;
      r = q;
      unique case (ln)
         LN_A16: begin
            s   = q.a + q.b;
            r.a = s;
            r.d = rotl32(q.d ^ s, 16);
         end
         LN_C12: begin
            s   = q.c + q.d;
            r.c = s;
            r.b = rotl32(q.b ^ s, 12);
         end
         LN_A8: begin
            s   = q.a + q.b;
            r.a = s;
            r.d = rotl32(q.d ^ s, 8);
         end
         LN_C7: begin
            s   = q.c + q.d;
            r.c = s;
            r.b = rotl32(q.b ^ s, 7);
         end
      endcase
      return r;
   endfunction

   // Block function program: load, column round, diagonal round, loop, feed
   function automatic ucode_type ucode_rom(input logic [UC_PC_W-1:0] pc);
      ucode_type w;
      w.op   = OP_FEED;
      w.line = LN_A16;
      w.diag = 1'b0;
      w.loop = 1'b0;
      unique case (pc)
         4'd0: w.op = OP_LOAD;
         4'd1: begin w.op = OP_ROUND; w.line = LN_A16; end
         4'd2: begin w.op = OP_ROUND; w.line = LN_C12; end
         4'd3: begin w.op = OP_ROUND; w.line = LN_A8;  end
         4'd4: begin w.op = OP_ROUND; w.line = LN_C7;  end
         4'd5: begin w.op = OP_ROUND; w.line = LN_A16; w.diag = 1'b1; end
         4'd6: begin w.op = OP_ROUND; w.line = LN_C12; w.diag = 1'b1; end
         4'd7: begin w.op = OP_ROUND; w.line = LN_A8;  w.diag = 1'b1; end
         4'd8: begin
            w.op   = OP_ROUND;
            w.line = LN_C7;
            w.diag = 1'b1;
            w.loop = 1'b1;
         end
         default: w.op = OP_FEED;
      endcase
      return w;
   endfunction

endpackage

// ----- rtl/core/cc20_block.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ChaCha20 block engine
// Microcoded sequencer over four quarter-round lanes; one quarter-round line
// per step, feed-forward add at the end of the program.
// ----------------------------------------------------------------------------
module cc20_block #(
   parameter int DOUBLE_ROUNDS = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cc20_pkg::blk_req_type blk_req,
   input  cc20_pkg::key_cfg_type key_cfg,
   output logic                  blk_done,
   output cc20_pkg::words_type   ks_words
);

   localparam int RND_W = $clog2(DOUBLE_ROUNDS + 1);
   localparam logic [RND_W-1:0] RND_LAST = RND_W'(DOUBLE_ROUNDS - 1);

   logic                         busy_ff, busy_in;
   logic [cc20_pkg::UC_PC_W-1:0] pc_ff, pc_in;
   logic [RND_W-1:0]             rnd_ff, rnd_in;
   cc20_pkg::ucode_type          uc;
   cc20_pkg::words_type          x_ff, x_in;
   cc20_pkg::words_type          work_ff, work_in;
   cc20_pkg::words_type          ks_ff, ks_in;
   cc20_pkg::words_type          init_words;

   // Fetch the control word
   assign uc = cc20_pkg::ucode_rom(pc_ff);

   // Block input words
   always_comb begin
      init_words[3:0] = cc20_pkg::SIGMA;
      for (int k = 0; k < 4; k++) begin
         init_words[4 + 2*k] = key_cfg.key[k][31:0];
         init_words[5 + 2*k] = key_cfg.key[k][63:32];
      end
      init_words[12] = blk_req.counter;
      init_words[13] = key_cfg.nonce_low[31:0];
      init_words[14] = key_cfg.nonce_low[63:32];
      init_words[15] = key_cfg.nonce_high;
   end

   // Step counter, round counter and loop jump
   always_comb begin
      busy_in = busy_ff;
      pc_in   = pc_ff;
      rnd_in  = rnd_ff;
      if (!busy_ff) begin
         if (blk_req.start) begin
            busy_in = 1'b1;
            pc_in   = '0;
         end
      end else begin
         unique case (uc.op)
            cc20_pkg::OP_LOAD: begin
               rnd_in = '0;
               pc_in  = pc_ff + 1'b1;
            end
            cc20_pkg::OP_ROUND: begin
               if (uc.loop && (rnd_ff != RND_LAST)) begin
                  rnd_in = rnd_ff + 1'b1;
                  pc_in  = cc20_pkg::UC_LOOP_TARGET;
               end else begin
                  pc_in = pc_ff + 1'b1;
               end
            end
            cc20_pkg::OP_FEED: busy_in = 1'b0;
            default: busy_in = 1'b0;
         endcase
      end
   end

   assign blk_done = busy_ff && (uc.op == cc20_pkg::OP_FEED);

   // Datapath: load, one line of four quarter rounds, or feed-forward
   always_comb begin
      logic [3:0]         ai, bi, ci, di;
      cc20_pkg::quad_type qin, qout;
      x_in    = x_ff;
      work_in = work_ff;
      ks_in   = ks_ff;
      ai      = '0;
      bi      = '0;
      ci      = '0;
      di      = '0;
      qin     = '0;
      qout    = '0;
      if (busy_ff) begin
         unique case (uc.op)
            cc20_pkg::OP_LOAD: begin
               work_in = init_words;
               x_in    = init_words;
            end
            cc20_pkg::OP_ROUND: begin
               for (int l = 0; l < 4; l++) begin
                  ai   = 4'(l);
                  bi   = {2'b01, 2'(l + int'(uc.diag))};
                  ci   = {2'b10, 2'(l + 2 * int'(uc.diag))};
                  di   = {2'b11, 2'(l + 3 * int'(uc.diag))};
                  qin  = {x_ff[ai], x_ff[bi], x_ff[ci], x_ff[di]};
                  qout = cc20_pkg::qr_line(uc.line, qin);
                  x_in[ai] = qout.a;
                  x_in[bi] = qout.b;
                  x_in[ci] = qout.c;
                  x_in[di] = qout.d;
               end
            end
            cc20_pkg::OP_FEED: begin
               for (int i = 0; i < 16; i++) begin
                  ks_in[i] = x_ff[i] + work_ff[i];
               end
            end
            default: ;
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= '0;
         rnd_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
         rnd_ff  <= rnd_in;
      end
   end

   // Word registers
   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      work_ff <= work_in;
      ks_ff   <= ks_in;
   end

   assign ks_words = ks_ff;

endmodule

// ----- rtl/core/chacha20_stream_cipher_top.sv -----
`timescale 1ns / 1ps
// A byte inside a ready keystream block gives its result in the cycle after accept.
// The first byte of each 64-byte block waits for the block engine: load, the round steps
// with one quarter-round line per step, then the feed-forward add.
// Throughput: 1 byte per cycle within a block while the output is not stalled; one block program per 64 bytes.
// Reset clears the state, configuration, block counter, byte position and keystream flag.
// ----------------------------------------------------------------------------
// ChaCha20 stream cipher top level
// Byte stream XOR with the ChaCha20 keystream; register file and stream control.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher_top #(
   parameter int DOUBLE_ROUNDS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  cc20_pkg::req_item_type              req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output cc20_pkg::rsp_item_type              rsp_data,
   input  logic                                csr_we,
   input  logic [cc20_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [63:0]                         csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_GEN  = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type              st_ff, st_in;
   cc20_pkg::key_cfg_type  cfg_ff, cfg_in;
   logic [31:0]            init_ctr_ff, init_ctr_in;
   logic [31:0]            ctr_ff, ctr_in;
   logic [5:0]             pos_ff, pos_in;
   logic                   ks_valid_ff, ks_valid_in;
   cc20_pkg::req_item_type hold_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   cc20_pkg::rsp_item_type rsp_data_ff;

   cc20_pkg::blk_req_type  blk_req;
   logic                   blk_done;
   cc20_pkg::words_type    ks_words;

   logic                   slot_free, accept, emit_direct, emit_held, emit;
   cc20_pkg::req_item_type emit_item;
   logic [31:0]            ks_word;
   logic [7:0]             ks_byte;

   // Handshake
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (st_ff == ST_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;

   // Emit at once on a ready keystream, else after the block program
   assign emit_direct = accept && ks_valid_ff;
   assign emit_held   = (st_ff == ST_EMIT) && slot_free;
   assign emit        = emit_direct || emit_held;
   assign emit_item   = emit_held ? hold_ff : req_data;

   assign ks_word = ks_words[pos_ff[5:2]];
   assign ks_byte = ks_word[{pos_ff[1:0], 3'b000} +: 8];

   assign blk_req.start   = accept && !ks_valid_ff;
   assign blk_req.counter = ctr_ff;

   cc20_block #(
      .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
   ) u_block (
      .clock    (clock),
      .reset    (reset),
      .blk_req  (blk_req),
      .key_cfg  (cfg_ff),
      .blk_done (blk_done),
      .ks_words (ks_words)
   );

   // Register file writes
   always_comb begin
      cfg_in      = cfg_ff;
      init_ctr_in = init_ctr_ff;
      if (csr_we) begin
         unique case (csr_index)
            cc20_pkg::CSR_KEY0:     cfg_in.key[0]     = csr_wdata;
            cc20_pkg::CSR_KEY1:     cfg_in.key[1]     = csr_wdata;
            cc20_pkg::CSR_KEY2:     cfg_in.key[2]     = csr_wdata;
            cc20_pkg::CSR_KEY3:     cfg_in.key[3]     = csr_wdata;
            cc20_pkg::CSR_NONCE_LO: cfg_in.nonce_low  = csr_wdata;
            cc20_pkg::CSR_NONCE_HI: cfg_in.nonce_high = csr_wdata[31:0];
            cc20_pkg::CSR_INIT_CTR: init_ctr_in       = csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // Sequence states
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: if (accept && !ks_valid_ff) st_in = ST_GEN;
         ST_GEN:  if (blk_done) st_in = ST_EMIT;
         ST_EMIT: if (emit_held) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   // Counter, byte position and keystream flag; later lines take priority
   always_comb begin
      ctr_in      = ctr_ff;
      pos_in      = pos_ff;
      ks_valid_in = ks_valid_ff;
      if (blk_done) begin
         ctr_in      = ctr_ff + 32'd1;
         ks_valid_in = 1'b1;
      end
      if (emit) begin
         if (emit_item.last_byte) begin
            ctr_in      = init_ctr_ff;
            pos_in      = '0;
            ks_valid_in = 1'b0;
         end else begin
            pos_in = pos_ff + 6'd1;
            if (pos_ff == 6'd63) begin
               ks_valid_in = 1'b0;
            end
         end
      end
      if (csr_we && (csr_index == cc20_pkg::CSR_INIT_CTR)) begin
         ctr_in = csr_wdata[31:0];
      end
   end

   // Output valid: set on emit, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         cfg_ff       <= '0;
         init_ctr_ff  <= '0;
         ctr_ff       <= '0;
         pos_ff       <= '0;
         ks_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         cfg_ff       <= cfg_in;
         init_ctr_ff  <= init_ctr_in;
         ctr_ff       <= ctr_in;
         pos_ff       <= pos_in;
         ks_valid_ff  <= ks_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Held item and output payload
   always_ff @(posedge clock) begin
      if (accept) begin
         hold_ff <= req_data;
      end
      if (emit) begin
         rsp_data_ff.out_byte        <= emit_item.data_byte ^ ks_byte;
         rsp_data_ff.last_of_message <= emit_item.last_byte;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/core/cc20_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ChaCha20 port checker
// Watches the top-level ports for stall and pacing rules of the stream.
// ----------------------------------------------------------------------------
`include "chacha20_stream_cipher_top_assert.svh"

module cc20_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input cc20_pkg::rsp_item_type rsp_data
);

   // A stalled result stays up
   `CC20_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // A stalled result keeps its bits
   `CC20_ASSERT_NXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_data))

   // No item enters while a result is stuck in the output register
   `CC20_ASSERT_IMP(a_no_overrun, clock, reset, req_valid && req_ready,
                    !rsp_valid || rsp_ready)

   // An item either shows its result next cycle or closes the input while the block runs
   `CC20_ASSERT_NXT(a_pace, clock, reset, req_valid && req_ready, rsp_valid || !req_ready)

endmodule

bind chacha20_stream_cipher_top cc20_checker u_cc20_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ----- tb/tb_chacha20_stream_cipher_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ChaCha20 stream cipher testbench
// Feeds byte messages through the cipher and checks every returned item
// against a local ChaCha20 keystream predictor. A directed table covers
// field extremes, the all-zero key after reset, message restarts and
// register writes in mid-message. Random phases follow, with changing key,
// nonce and counter settings (counter wrap included) and random gaps on
// both handshakes.
// ----------------------------------------------------------------------------
module tb_chacha20_stream_cipher_top;

   localparam int ROUND_PAIRS   = 10;
   localparam int ENGINE_CYCLES = 8 * ROUND_PAIRS + 3;
   localparam int TIMEOUT_NS    = 2_000_000;
   localparam int PHASES        = 12;
   localparam int PHASE_BYTES   = 146;
   localparam int REPORT_LIMIT  = 10;

   // Index with no register behind it
   localparam logic [cc20_pkg::CSR_IDX_W-1:0] CSR_SPARE = 3'd7;

   typedef enum logic {ROW_BYTE, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type                    kind;
      logic [cc20_pkg::CSR_IDX_W-1:0]  index;
      logic [63:0]                     value;
      logic [7:0]                      data;
      logic                            last;
      logic                            fixed;
      logic [7:0]                      exp_byte;
   } dir_row_type;

   function automatic dir_row_type byte_row(input logic [7:0] data, input logic last,
                                            input logic fixed, input logic [7:0] exp_byte);
      dir_row_type r;
      r = '0;
      r.kind     = ROW_BYTE;
      r.data     = data;
      r.last     = last;
      r.fixed    = fixed;
      r.exp_byte = exp_byte;
      return r;
   endfunction

   function automatic dir_row_type csr_row(input logic [cc20_pkg::CSR_IDX_W-1:0] index,
                                           input logic [63:0] value);
      dir_row_type r;
      r = '0;
      r.kind  = ROW_CSR;
      r.index = index;
      r.value = value;
      return r;
   endfunction

   // Directed table; typed-in results are the all-zero key keystream
   // (76 b8 e0 ad ...) right after reset
   localparam int DIR_ROWS = 33;
   localparam dir_row_type DIRECTED [DIR_ROWS] = '{
      byte_row(8'h00, 1'b0, 1'b1, 8'h76),
      byte_row(8'h00, 1'b0, 1'b1, 8'hb8),
      byte_row(8'hff, 1'b0, 1'b1, 8'h1f),
      byte_row(8'hff, 1'b0, 1'b1, 8'h52),
      byte_row(8'h3c, 1'b1, 1'b0, 8'h00),
      // new message restarts at counter 0, byte 0
      byte_row(8'h00, 1'b1, 1'b1, 8'h76),
      csr_row(cc20_pkg::CSR_KEY0, 64'h0706050403020100),
      csr_row(cc20_pkg::CSR_KEY1, 64'h0f0e0d0c0b0a0908),
      csr_row(cc20_pkg::CSR_KEY2, 64'h1716151413121110),
      csr_row(cc20_pkg::CSR_KEY3, 64'h1f1e1d1c1b1a1918),
      csr_row(cc20_pkg::CSR_NONCE_LO, 64'h4a00000000000000),
      csr_row(cc20_pkg::CSR_NONCE_HI, 64'h0),
      csr_row(cc20_pkg::CSR_INIT_CTR, 64'h1),
      csr_row(CSR_SPARE, 64'hffffffffffffffff),
      byte_row(8'h4c, 1'b0, 1'b0, 8'h00),
      byte_row(8'h61, 1'b0, 1'b0, 8'h00),
      byte_row(8'h64, 1'b0, 1'b0, 8'h00),
      byte_row(8'h69, 1'b0, 1'b0, 8'h00),
      byte_row(8'h65, 1'b0, 1'b0, 8'h00),
      byte_row(8'h73, 1'b0, 1'b0, 8'h00),
      byte_row(8'h20, 1'b0, 1'b0, 8'h00),
      byte_row(8'h61, 1'b0, 1'b0, 8'h00),
      // key and counter change in mid-message: current block is kept
      csr_row(cc20_pkg::CSR_KEY0, 64'hffffffffffffffff),
      csr_row(cc20_pkg::CSR_INIT_CTR, 64'h00000000ffffffff),
      byte_row(8'h6e, 1'b0, 1'b0, 8'h00),
      byte_row(8'h64, 1'b0, 1'b0, 8'h00),
      byte_row(8'h20, 1'b0, 1'b0, 8'h00),
      byte_row(8'h47, 1'b0, 1'b0, 8'h00),
      byte_row(8'hff, 1'b1, 1'b0, 8'h00),
      csr_row(cc20_pkg::CSR_NONCE_HI, 64'h00000000ffffffff),
      csr_row(cc20_pkg::CSR_NONCE_LO, 64'hffffffffffffffff),
      byte_row(8'h80, 1'b1, 1'b0, 8'h00),
      byte_row(8'h01, 1'b1, 1'b0, 8'h00)
   };

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   cc20_pkg::req_item_type         req_data = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   cc20_pkg::rsp_item_type         rsp_data;
   logic                           csr_we = 1'b0;
   logic [cc20_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [63:0]                    csr_wdata = '0;

   // Idle percentages for the two handshakes
   int send_gap_pct = 0;
   int recv_gap_pct = 0;

   // Predictor state
   logic [63:0]         key_cfg [4];
   logic [63:0]         nonce_lo_cfg;
   logic [31:0]         nonce_hi_cfg;
   logic [31:0]         ctr_start;
   logic [31:0]         ctr_now;
   logic [5:0]          byte_pos;
   logic                ks_ready;
   cc20_pkg::words_type ks_block;

   cc20_pkg::rsp_item_type cipher_out_queue [$];

   int  fail_count    = 0;
   int  bytes_sent    = 0;
   int  messages_sent = 0;
   int  csr_writes    = 0;
   int  blocks_made   = 0;
   int  counter_wraps = 0;
   int  results_seen  = 0;
   bit  stream_busy   = 1'b0;

   chacha20_stream_cipher_top #(
      .DOUBLE_ROUNDS(ROUND_PAIRS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [31:0] rot_left(input logic [31:0] v, input int n);
      logic [63:0] both;
      both = {v, v} << n;
      return both[63:32];
   endfunction

   function automatic logic [127:0] quarter_mix(input logic [31:0] a, b, c, d);
      a = a + b; d = rot_left(d ^ a, 16);
      c = c + d; b = rot_left(b ^ c, 12);
      a = a + b; d = rot_left(d ^ a, 8);
      c = c + d; b = rot_left(b ^ c, 7);
      return {a, b, c, d};
   endfunction

   // One keystream block from the current key, nonce and the given counter
   function automatic cc20_pkg::words_type keystream_block(input logic [31:0] ctr);
      logic [31:0]         init_w [16];
      logic [31:0]         x [16];
      cc20_pkg::words_type blk;
      int                  a, b, c, d;
      for (int i = 0; i < 4; i++) begin
         init_w[i]         = cc20_pkg::SIGMA[i];
         init_w[4 + 2 * i] = key_cfg[i][31:0];
         init_w[5 + 2 * i] = key_cfg[i][63:32];
      end
      init_w[12] = ctr;
      init_w[13] = nonce_lo_cfg[31:0];
      init_w[14] = nonce_lo_cfg[63:32];
      init_w[15] = nonce_hi_cfg;
      x = init_w;
      for (int r = 0; r < ROUND_PAIRS; r++) begin
         for (int i = 0; i < 4; i++) begin
            {x[i], x[4 + i], x[8 + i], x[12 + i]} =
               quarter_mix(x[i], x[4 + i], x[8 + i], x[12 + i]);
         end
         for (int i = 0; i < 4; i++) begin
            a = i;
            b = 4 + (i + 1) % 4;
            c = 8 + (i + 2) % 4;
            d = 12 + (i + 3) % 4;
            {x[a], x[b], x[c], x[d]} = quarter_mix(x[a], x[b], x[c], x[d]);
         end
      end
      for (int i = 0; i < 16; i++) blk[i] = x[i] + init_w[i];
      return blk;
   endfunction

   // Advance the stream by one byte and return the ciphered item
   task automatic cipher_predict(input cc20_pkg::req_item_type item,
                                 output cc20_pkg::rsp_item_type res);
      logic [31:0] word;
      if (!ks_ready) begin
         if (ctr_now == '1) counter_wraps++;
         ks_block = keystream_block(ctr_now);
         ctr_now  = ctr_now + 32'd1;
         ks_ready = 1'b1;
         blocks_made++;
      end
      word = ks_block[byte_pos[5:2]];
      res.out_byte        = item.data_byte ^ word[{byte_pos[1:0], 3'b000} +: 8];
      res.last_of_message = item.last_byte;
      if (item.last_byte) begin
         ctr_now  = ctr_start;
         byte_pos = '0;
         ks_ready = 1'b0;
      end else begin
         if (byte_pos == 6'd63) ks_ready = 1'b0;
         byte_pos = byte_pos + 6'd1;
      end
   endtask

   // Write one register; enter and leave at a falling edge
   task automatic write_csr(input logic [cc20_pkg::CSR_IDX_W-1:0] index,
                            input logic [63:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      unique case (index)
         cc20_pkg::CSR_KEY0:     key_cfg[0] = value;
         cc20_pkg::CSR_KEY1:     key_cfg[1] = value;
         cc20_pkg::CSR_KEY2:     key_cfg[2] = value;
         cc20_pkg::CSR_KEY3:     key_cfg[3] = value;
         cc20_pkg::CSR_NONCE_LO: nonce_lo_cfg = value;
         cc20_pkg::CSR_NONCE_HI: nonce_hi_cfg = value[31:0];
         cc20_pkg::CSR_INIT_CTR: begin
            ctr_start = value[31:0];
            ctr_now   = value[31:0];
         end
         default: ;
      endcase
      csr_writes++;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Offer one item, hold it until accepted, then log its expected result
   task automatic feed_byte(input cc20_pkg::req_item_type item, input logic use_fixed,
                            input cc20_pkg::rsp_item_type fixed);
      cc20_pkg::rsp_item_type predicted;
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      cipher_predict(item, predicted);
      cipher_out_queue.push_back(use_fixed ? fixed : predicted);
      bytes_sent++;
      if (item.last_byte) messages_sent++;
      stream_busy = 1'b1;
      @(negedge clock);
   endtask

   // Drop valid and let all results drain plus the block engine settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (cipher_out_queue.size() != 0) @(negedge clock);
      repeat (ENGINE_CYCLES + 4) @(negedge clock);
      stream_busy = 1'b0;
   endtask

   // Receiver stalls
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_gap_pct);
   end

   // Check each returned item against the oldest expectation
   always @(posedge clock) begin
      cc20_pkg::rsp_item_type exp_item;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (cipher_out_queue.size() == 0) begin
            if (fail_count < REPORT_LIMIT)
               $display("ERROR: unexpected result out_byte=%02h last=%0b at %0t",
                        rsp_data.out_byte, rsp_data.last_of_message, $realtime);
            fail_count++;
         end else begin
            exp_item = cipher_out_queue.pop_front();
            if (rsp_data.out_byte !== exp_item.out_byte ||
                rsp_data.last_of_message !== exp_item.last_of_message) begin
               if (fail_count < REPORT_LIMIT)
                  $display("ERROR: result %0d: out_byte exp %02h got %02h, last exp %0b got %0b",
                           results_seen, exp_item.out_byte, rsp_data.out_byte,
                           exp_item.last_of_message, rsp_data.last_of_message);
               fail_count++;
            end
         end
      end
   end

   // Stop a hung run
   initial begin
      #(TIMEOUT_NS);
      $display("Timeout with %0d results outstanding", cipher_out_queue.size());
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      cc20_pkg::req_item_type item;
      cc20_pkg::rsp_item_type fixed_rsp;
      int                     msg_left;
      int                     style;

      for (int i = 0; i < 4; i++) key_cfg[i] = '0;
      nonce_lo_cfg = '0;
      nonce_hi_cfg = '0;
      ctr_start    = '0;
      ctr_now      = '0;
      byte_pos     = '0;
      ks_ready     = 1'b0;
      ks_block     = '0;
      msg_left     = 0;

      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Directed table, sender idling 36 and receiver 62 in a hundred
      send_gap_pct = 36;
      recv_gap_pct = 62;
      for (int r = 0; r < DIR_ROWS; r++) begin
         if (DIRECTED[r].kind == ROW_CSR) begin
            if (stream_busy) wait_idle();
            write_csr(DIRECTED[r].index, DIRECTED[r].value);
         end else begin
            item.data_byte            = DIRECTED[r].data;
            item.last_byte            = DIRECTED[r].last;
            fixed_rsp.out_byte        = DIRECTED[r].exp_byte;
            fixed_rsp.last_of_message = DIRECTED[r].last;
            feed_byte(item, DIRECTED[r].fixed, fixed_rsp);
         end
      end

      // Random phases; a message may run on across a register change
      for (int p = 0; p < PHASES; p++) begin
         if (p < PHASES / 3) begin
            send_gap_pct = 36;
            recv_gap_pct = 62;
         end else if (p < 2 * PHASES / 3) begin
            send_gap_pct = 62;
            recv_gap_pct = 36;
         end else begin
            send_gap_pct = 0;
            recv_gap_pct = 0;
         end
         wait_idle();
         style = p % 4;
         case (style)
            0: begin
               for (int i = cc20_pkg::CSR_KEY0; i <= cc20_pkg::CSR_INIT_CTR; i++)
                  write_csr(i[cc20_pkg::CSR_IDX_W-1:0], {$urandom, $urandom});
            end
            1: begin
               for (int i = cc20_pkg::CSR_KEY0; i <= cc20_pkg::CSR_INIT_CTR; i++)
                  write_csr(i[cc20_pkg::CSR_IDX_W-1:0], '1);
            end
            2: begin
               for (int i = cc20_pkg::CSR_KEY0; i < cc20_pkg::CSR_INIT_CTR; i++)
                  write_csr(i[cc20_pkg::CSR_IDX_W-1:0], '0);
               write_csr(cc20_pkg::CSR_INIT_CTR, 64'h00000000fffffffe);
            end
            default: begin
               for (int i = cc20_pkg::CSR_KEY0; i < cc20_pkg::CSR_INIT_CTR; i++)
                  if ($urandom_range(1))
                     write_csr(i[cc20_pkg::CSR_IDX_W-1:0], {$urandom, $urandom});
               write_csr(CSR_SPARE, {$urandom, $urandom});
               write_csr(cc20_pkg::CSR_INIT_CTR, '0);
            end
         endcase
         // Run long enough past the counter top to wrap it
         if (style == 1 || style == 2) msg_left += 130;
         for (int n = 0; n < PHASE_BYTES; n++) begin
            if (msg_left == 0) begin
               case ($urandom_range(9))
                  0:       msg_left = $urandom_range(100, 200);
                  1:       msg_left = 63 + $urandom_range(2);
                  2, 3:    msg_left = $urandom_range(17, 80);
                  default: msg_left = $urandom_range(1, 16);
               endcase
            end
            item.data_byte = $urandom;
            item.last_byte = (msg_left == 1);
            msg_left--;
            feed_byte(item, 1'b0, '0);
         end
      end

      // Drain and let any late items show up
      req_valid <= 1'b0;
      while (cipher_out_queue.size() != 0) @(negedge clock);
      repeat (ENGINE_CYCLES + 20) @(negedge clock);

      $display("Sent %0d bytes in %0d messages with %0d register writes; %0d results",
               bytes_sent, messages_sent, csr_writes, results_seen);
      $display("Predicted %0d keystream blocks, %0d counter wraps, %0d mismatches",
               blocks_made, counter_wraps, fail_count);
      if (fail_count == 0 && cipher_out_queue.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
